FILE: rtl/core/swsnd_pkg.sv
// swsnd_pkg: types and constants shared by the sliding window sender modules
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package swsnd_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int SLOT_W     = $clog2(WINDOW_MAX);
   localparam int WIN_W      = SLOT_W + 1;
   localparam int SEQ_W      = 16;
   localparam int BASE_W     = SEQ_W + 1;
   localparam int LEN_W      = 11;
   localparam int OFFSET_W   = 27;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_ACK     = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FLIGHT_LIMIT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_MODE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PACKETS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_SIZE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_LENGTH   = 3'd4;

   localparam logic [WIN_W-1:0]  FLIGHT_LIMIT_RESET = 7'd8;
   localparam logic              REPEAT_MODE_RESET  = 1'b1;
   localparam logic [SEQ_W-1:0]  TOTAL_RESET        = 16'd0;
   localparam logic [LEN_W-1:0]  PAYLOAD_SIZE_RESET = 11'd1450;
   localparam logic [LEN_W-1:0]  LAST_LENGTH_RESET  = 11'd1450;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [BASE_W-1:0] ack_seq;
   } req_type;

   typedef struct packed {
      logic                send_valid;
      logic [SEQ_W-1:0]    send_seq;
      logic [OFFSET_W-1:0] byte_offset;
      logic [LEN_W-1:0]    byte_length;
      logic [BASE_W-1:0]   window_base;
      logic                ack_ignored;
      logic                transfer_done;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [WIN_W-1:0] flight_limit;
      logic             repeat_mode;
      logic [SEQ_W-1:0] total_packets;
      logic [LEN_W-1:0] payload_size;
      logic [LEN_W-1:0] last_length;
   } cfg_type;

   // one burst order from the front to the back
   typedef struct packed {
      logic [BASE_W-1:0]     base;
      logic                  ignored;
      logic                  done;
      logic [WINDOW_MAX-1:0] mask;
   } cmd_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_SLIDE,
      FE_PUSH
   } fe_state_type;

endpackage

FILE: rtl/core/swsnd_front.sv
// swsnd_front: takes events, updates window base and acked ring, builds burst orders
// depends on swsnd_pkg
`timescale 1ns / 1ps

module swsnd_front (
   input  logic               clock,
   input  logic               reset,
   input  swsnd_pkg::cfg_type cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  swsnd_pkg::req_type req_payload,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output swsnd_pkg::cmd_type cmd
);
   import swsnd_pkg::*;

   fe_state_type          state_ff, state_in;
   logic [BASE_W-1:0]     base_ff, base_in;
   logic [WINDOW_MAX-1:0] ring_ff, ring_in;
   logic                  send_ff, send_in;
   logic                  ign_ff, ign_in;

   logic [WIN_W-1:0]      w_eff;
   logic [BASE_W:0]       top_sum, tot_ext, top, ack_ext;
   logic [WIN_W-1:0]      adv;
   logic [WINDOW_MAX-1:0] clr_mask, rot, send_mask;
   logic [2*WINDOW_MAX-1:0] ring_dbl;
   logic [BASE_W-1:0]     tot_base, diff;
   logic [WIN_W-1:0]      lim;
   logic [SLOT_W-1:0]     slot_off;

   always_comb begin
      if (cfg.flight_limit == '0) begin
         w_eff = WIN_W'(1);
      end else if (cfg.flight_limit > WIN_W'(WINDOW_MAX)) begin
         w_eff = WIN_W'(WINDOW_MAX);
      end else begin
         w_eff = cfg.flight_limit;
      end
   end

   assign tot_base = {1'b0, cfg.total_packets};
   assign tot_ext  = {2'b00, cfg.total_packets};
   assign top_sum  = {1'b0, base_ff} + (BASE_W+1)'(w_eff);
   assign top      = (top_sum > tot_ext) ? tot_ext : top_sum;
   assign ack_ext  = {1'b0, req_payload.ack_seq};
   // go-back-n advance never exceeds one window, so the low bits hold it
   assign adv      = WIN_W'(req_payload.ack_seq - base_ff);

   always_comb begin
      for (int j = 0; j < WINDOW_MAX; j++) begin
         slot_off    = SLOT_W'(j) - base_ff[SLOT_W-1:0];
         clr_mask[j] = {1'b0, slot_off} < adv;
      end
   end

   // ring seen from the base slot onwards
   assign ring_dbl = {ring_ff, ring_ff} >> base_ff[SLOT_W-1:0];
   assign rot      = ring_dbl[WINDOW_MAX-1:0];
   assign diff     = tot_base - base_ff;

   always_comb begin
      if (base_ff >= tot_base) begin
         lim = '0;
      end else if (diff < BASE_W'(w_eff)) begin
         lim = WIN_W'(diff);
      end else begin
         lim = w_eff;
      end
      for (int i = 0; i < WINDOW_MAX; i++) begin
         send_mask[i] = (WIN_W'(i) < lim) && !(cfg.repeat_mode && rot[i]);
      end
   end

   always_comb begin
      cmd.base    = base_ff;
      cmd.ignored = ign_ff;
      cmd.done    = base_ff >= tot_base;
      cmd.mask    = send_ff ? send_mask : '0;
   end

   always_comb begin
      state_in  = state_ff;
      base_in   = base_ff;
      ring_in   = ring_ff;
      send_in   = send_ff;
      ign_in    = ign_ff;
      req_stall = 1'b1;
      cmd_valid = 1'b0;
      unique case (state_ff)
         FE_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               send_in  = 1'b0;
               ign_in   = 1'b0;
               state_in = FE_PUSH;
               unique case (req_payload.opcode)
                  OP_START: begin
                     base_in = '0;
                     ring_in = '0;
                     send_in = 1'b1;
                  end
                  OP_ACK: begin
                     if (!cfg.repeat_mode) begin
                        if (req_payload.ack_seq > base_ff && ack_ext <= top) begin
                           base_in = req_payload.ack_seq;
                           ring_in = ring_ff & ~clr_mask;
                           send_in = 1'b1;
                        end else begin
                           ign_in = 1'b1;
                        end
                     end else begin
                        if (req_payload.ack_seq >= base_ff && ack_ext < top) begin
                           ring_in[req_payload.ack_seq[SLOT_W-1:0]] = 1'b1;
                           if (req_payload.ack_seq == base_ff) begin
                              send_in  = 1'b1;
                              state_in = FE_SLIDE;
                           end
                        end else begin
                           ign_in = 1'b1;
                        end
                     end
                  end
                  OP_TIMEOUT: begin
                     send_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         FE_SLIDE: begin
            // base walks past acked slots, one per cycle
            if (base_ff < tot_base && ring_ff[base_ff[SLOT_W-1:0]]) begin
               ring_in[base_ff[SLOT_W-1:0]] = 1'b0;
               base_in = base_ff + BASE_W'(1);
            end else begin
               state_in = FE_PUSH;
            end
         end
         FE_PUSH: begin
            cmd_valid = 1'b1;
            if (cmd_ready) begin
               state_in = FE_IDLE;
            end
         end
         default: begin
            state_in = FE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
         base_ff  <= '0;
         ring_ff  <= '0;
         send_ff  <= 1'b0;
         ign_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         ring_ff  <= ring_in;
         send_ff  <= send_in;
         ign_ff   <= ign_in;
      end
   end

   a_push_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FE_PUSH && cmd_ready) |=> (state_ff == FE_IDLE))
      else $error("front did not return to idle after handing over an order");

   a_slide_from_ack: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FE_IDLE && state_in == FE_SLIDE) |->
      (req_valid && req_payload.opcode == OP_ACK && cfg.repeat_mode))
      else $error("slide entered without a selective ack");

endmodule

FILE: rtl/core/swsnd_queue.sv
// swsnd_queue: short order queue between front and back
// depends on swsnd_pkg
`timescale 1ns / 1ps

module swsnd_queue #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               push_ready,
   input  swsnd_pkg::cmd_type push_data,
   output logic               pop_valid,
   input  logic               pop,
   output swsnd_pkg::cmd_type pop_data
);
   import swsnd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("order queue overfilled");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("order queue count out of step with pushes");

endmodule

FILE: rtl/core/swsnd_back.sv
// swsnd_back: walks one burst order slot by slot and emits send requests
// depends on swsnd_pkg
`timescale 1ns / 1ps

module swsnd_back (
   input  logic               clock,
   input  logic               reset,
   input  swsnd_pkg::cfg_type cfg,
   input  logic               cmd_valid,
   output logic               cmd_pop,
   input  swsnd_pkg::cmd_type cmd,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output swsnd_pkg::rsp_type rsp_payload
);
   import swsnd_pkg::*;

   logic              busy_ff, busy_in;
   cmd_type           cmd_ff, cmd_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [BASE_W-1:0] seq_ff, seq_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic                  out_free;
   logic [WINDOW_MAX-1:0] upper;
   logic                  is_last;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign cmd_pop   = !busy_ff && cmd_valid;
   assign upper     = (cmd_ff.mask >> idx_ff) >> 1;
   assign is_last   = upper == '0;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      busy_in      = busy_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      seq_in       = seq_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      if (cmd_pop) begin
         busy_in = 1'b1;
         cmd_in  = cmd;
         idx_in  = '0;
         seq_in  = cmd.base;
      end else if (busy_ff) begin
         if (cmd_ff.mask == '0) begin
            // nothing to send: one status item
            if (out_free) begin
               out_valid_in          = 1'b1;
               out_in.send_valid     = 1'b0;
               out_in.send_seq       = '0;
               out_in.byte_offset    = '0;
               out_in.byte_length    = '0;
               out_in.window_base    = cmd_ff.base;
               out_in.ack_ignored    = cmd_ff.ignored;
               out_in.transfer_done  = cmd_ff.done;
               out_in.last           = 1'b1;
               busy_in               = 1'b0;
            end
         end else if (cmd_ff.mask[idx_ff]) begin
            if (out_free) begin
               out_valid_in          = 1'b1;
               out_in.send_valid     = 1'b1;
               out_in.send_seq       = seq_ff[SEQ_W-1:0];
               out_in.byte_offset    = OFFSET_W'(seq_ff[SEQ_W-1:0])
                                       * OFFSET_W'(cfg.payload_size);
               out_in.byte_length    = (seq_ff + BASE_W'(1) == {1'b0, cfg.total_packets})
                                       ? cfg.last_length : cfg.payload_size;
               out_in.window_base    = cmd_ff.base;
               out_in.ack_ignored    = 1'b0;
               out_in.transfer_done  = cmd_ff.done;
               out_in.last           = is_last;
               if (is_last) begin
                  busy_in = 1'b0;
               end else begin
                  idx_in = idx_ff + SLOT_W'(1);
                  seq_in = seq_ff + BASE_W'(1);
               end
            end
         end else begin
            // acked slot, skipped
            idx_in = idx_ff + SLOT_W'(1);
            seq_in = seq_ff + BASE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      seq_ff <= seq_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.send_valid) |-> out_ff.last)
      else $error("status item without last mark");

   a_pop_starts_burst: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (busy_ff && idx_ff == '0))
      else $error("burst did not start at the first slot");

endmodule

FILE: rtl/core/sliding_window_sender.sv
// sliding_window_sender: top level, configuration registers, front, order queue, back
// depends on swsnd_pkg, swsnd_front, swsnd_queue, swsnd_back
//
//   channel  | direction | handshake            | payload
//   req_     | in        | req_valid/req_stall  | req_payload  (opcode, ack_seq)
//   rsp_     | out       | rsp_valid/rsp_stall  | rsp_payload  (one send request or status)
//   csr_     | in        | csr_wr_en            | csr_index, csr_wdata
//
// an event is taken in idle; a selective ack at the base slides the base past the acked
// run, and the front hands its order to the queue, waiting there while the queue is full
// the back loads an order, then walks the window slots in order up to the last packet sent,
// stepping over acked slots, or emits a lone status item; a stalled output holds each send
// throughput is set by the slower side; the queue lets the front run ahead of the back
// reset is synchronous; it restores register defaults, base zero and a clear ring
// rsp_stall holds the output register; the front keeps taking events until the queue fills
`timescale 1ns / 1ps

module sliding_window_sender #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  swsnd_pkg::req_type                       req_payload,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output swsnd_pkg::rsp_type                       rsp_payload,
   input  logic                                     csr_wr_en,
   input  logic [swsnd_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [swsnd_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import swsnd_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    q_push, q_push_ready, q_pop_valid, q_pop;
   cmd_type q_push_data, q_pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FLIGHT_LIMIT:  cfg_in.flight_limit  = csr_wdata[WIN_W-1:0];
            CSR_REPEAT_MODE:   cfg_in.repeat_mode   = csr_wdata[0];
            CSR_TOTAL_PACKETS: cfg_in.total_packets = csr_wdata[SEQ_W-1:0];
            CSR_PAYLOAD_SIZE:  cfg_in.payload_size  = csr_wdata[LEN_W-1:0];
            CSR_LAST_LENGTH:   cfg_in.last_length   = csr_wdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flight_limit  <= FLIGHT_LIMIT_RESET;
         cfg_ff.repeat_mode   <= REPEAT_MODE_RESET;
         cfg_ff.total_packets <= TOTAL_RESET;
         cfg_ff.payload_size  <= PAYLOAD_SIZE_RESET;
         cfg_ff.last_length   <= LAST_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   swsnd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cmd_valid   (q_push),
      .cmd_ready   (q_push_ready),
      .cmd         (q_push_data)
   );

   swsnd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop        (q_pop),
      .pop_data   (q_pop_data)
   );

   swsnd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cmd_valid   (q_pop_valid),
      .cmd_pop     (q_pop),
      .cmd         (q_pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: tb/sliding_window_sender_tb.sv
// sliding_window_sender_tb: self-checking bench for the sliding window sender controller
// needs swsnd_pkg and sliding_window_sender; a local window predictor checks every result item
// directed phases over all register extremes, then random transfers with bursty traffic
`timescale 1ns / 1ps

module sliding_window_sender_tb;
   import swsnd_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int QUIET_LIMIT     = 4000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int ITEM_TARGET     = 500;
   localparam int REPORT_CAP      = 100;

   typedef struct packed {
      logic [BASE_W-1:0]     base;
      logic [WINDOW_MAX-1:0] acked;
   } window_state_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   req_type            req_payload;
   logic               rsp_valid;
   logic               rsp_stall;
   rsp_type            rsp_payload;
   logic               csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   cfg_type          reg_copy;
   window_state_type win_checked;  // advanced as items are accepted
   window_state_type win_planned;  // advanced as items are queued
   req_type          pending_items[$];
   rsp_type          expected_sends[$];
   rsp_type          burst_scratch[$];

   int  queued_cnt = 0;
   int  accepted_cnt = 0;
   int  checked_cnt = 0;
   int  send_cnt = 0;
   int  error_cnt = 0;
   int  quiet_cycles = 0;
   int  gbn_cnt = 0;
   int  sr_cnt = 0;
   int  write_cnt = 0;
   int  holds_done = 0;
   bit  req_taken = 1'b0;

   sliding_window_sender u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int eff_window(cfg_type c);
      if (c.flight_limit == 0) return 1;
      if (c.flight_limit > WINDOW_MAX) return WINDOW_MAX;
      return int'(c.flight_limit);
   endfunction

   function automatic rsp_type send_request(cfg_type c, window_state_type st, bit valid,
                                            int seq, bit ignored);
      rsp_type r;
      longint  off;
      r = '0;
      if (valid) begin
         off = longint'(seq) * longint'(c.payload_size);
         r.send_valid  = 1'b1;
         r.send_seq    = seq[SEQ_W-1:0];
         r.byte_offset = off[OFFSET_W-1:0];
         r.byte_length = (seq + 1 == int'(c.total_packets)) ? c.last_length : c.payload_size;
      end
      r.window_base   = st.base;
      r.ack_ignored   = ignored;
      r.transfer_done = (int'(st.base) >= int'(c.total_packets));
      return r;
   endfunction

   // sends from the base up to the window edge, skipping acked slots in selective repeat
   function automatic void push_window(cfg_type c, window_state_type st);
      int s;
      for (int i = 0; i < eff_window(c); i++) begin
         s = int'(st.base) + i;
         if (s >= int'(c.total_packets)) break;
         if (c.repeat_mode && st.acked[s % WINDOW_MAX]) continue;
         burst_scratch.push_back(send_request(c, st, 1'b1, s, 1'b0));
      end
   endfunction

   // one event: updates the window state and leaves its result items in burst_scratch
   function automatic void window_event(cfg_type c, inout window_state_type st, input req_type r);
      int      base;
      int      ack;
      int      top;
      int      tot;
      bit      ignored;
      rsp_type tail;
      base    = int'(st.base);
      ack     = int'(r.ack_seq);
      tot     = int'(c.total_packets);
      top     = base + eff_window(c);
      ignored = 1'b0;
      if (top > tot) top = tot;
      burst_scratch.delete();
      case (r.opcode)
         OP_START: begin
            st = '0;
            push_window(c, st);
         end
         OP_ACK: begin
            if (!c.repeat_mode) begin
               // cumulative ack names the next expected packet
               if (ack > base && ack <= top) begin
                  while (int'(st.base) < ack) begin
                     st.acked[st.base[SLOT_W-1:0]] = 1'b0;
                     st.base = st.base + 1'b1;
                  end
                  push_window(c, st);
               end else begin
                  ignored = 1'b1;
               end
            end else begin
               if (ack >= base && ack < top) begin
                  st.acked[ack % WINDOW_MAX] = 1'b1;
                  if (ack == base) begin
                     while (int'(st.base) < tot && st.acked[st.base[SLOT_W-1:0]]) begin
                        st.acked[st.base[SLOT_W-1:0]] = 1'b0;
                        st.base = st.base + 1'b1;
                     end
                     push_window(c, st);
                  end
               end else begin
                  ignored = 1'b1;
               end
            end
         end
         OP_TIMEOUT: begin
            push_window(c, st);
         end
         default: ;
      endcase
      if (burst_scratch.size() == 0) burst_scratch.push_back(send_request(c, st, 1'b0, 0, ignored));
      tail = burst_scratch.pop_back();
      tail.last = 1'b1;
      burst_scratch.push_back(tail);
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         error_cnt++;
         if (error_cnt <= REPORT_CAP) $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   // acceptance on both channels, result checking and the quiet-cycle watchdog
   always @(posedge clock) begin : accept_side
      rsp_type want;
      bit      busy;
      if (!reset) begin
         busy = 1'b0;
         if (req_valid && !req_stall) begin
            if (reg_copy.repeat_mode) sr_cnt++;
            else gbn_cnt++;
            window_event(reg_copy, win_checked, req_payload);
            foreach (burst_scratch[k]) expected_sends.push_back(burst_scratch[k]);
            accepted_cnt++;
            req_taken = 1'b1;
            busy = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            busy = 1'b1;
            if (expected_sends.size() == 0) begin
               error_cnt++;
               if (error_cnt <= REPORT_CAP) $error("unexpected result item: %p", rsp_payload);
            end else begin
               want = expected_sends.pop_front();
               check_field("send_valid", want.send_valid, rsp_payload.send_valid);
               check_field("send_seq", want.send_seq, rsp_payload.send_seq);
               check_field("byte_offset", want.byte_offset, rsp_payload.byte_offset);
               check_field("byte_length", want.byte_length, rsp_payload.byte_length);
               check_field("window_base", want.window_base, rsp_payload.window_base);
               check_field("ack_ignored", want.ack_ignored, rsp_payload.ack_ignored);
               check_field("transfer_done", want.transfer_done, rsp_payload.transfer_done);
               check_field("last", want.last, rsp_payload.last);
               checked_cnt++;
               if (want.send_valid) send_cnt++;
            end
         end
         if (busy) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("** sliding_window_sender: FAILED **");
            $finish;
         end
      end
   end

   // sender: bursts of items with random gaps, payload held until taken
   always @(negedge clock) begin : req_driver
      static int burst_left = 1;
      static int gap_left = 0;
      if (!reset && !(req_valid && !req_taken)) begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_payload <= pending_items.pop_front();
            req_valid   <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                        : $urandom_range(1, 12);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern switches between free running, random, periodic and heavy
   always @(negedge clock) begin : rsp_receiver
      static int mode = 0;
      static int mode_left = 50;
      static int hold_left = 0;
      static int tick = 0;
      bit        stall;
      if (!reset) begin
         tick++;
         stall = 1'b0;
         // hold off only while the sender still has items to offer
         if (hold_left == 0 && pending_items.size() >= 8 &&
             ((holds_done == 0 && accepted_cnt >= 120) ||
              (holds_done == 1 && accepted_cnt >= 380))) begin
            hold_left = HOLD_OFF_CYCLES;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall = 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end else begin
               mode_left--;
            end
            case (mode)
               1: stall = ($urandom_range(0, 3) == 0);
               2: stall = (tick % 4 == 0);
               3: stall = ($urandom_range(0, 3) != 0);
               default: stall = 1'b0;
            endcase
         end
         rsp_stall <= stall;
      end
   end

   // queues one item and advances the planned window
   function automatic void queue_item(logic [1:0] op, int ack);
      req_type item;
      item.opcode  = op;
      item.ack_seq = ack[BASE_W-1:0];
      pending_items.push_back(item);
      queued_cnt++;
      window_event(reg_copy, win_planned, item);
   endfunction

   // mostly acks aimed inside the window, plus timeouts, restarts and stray values
   function automatic void queue_random_item();
      int w;
      int b;
      int tot;
      int sel;
      int ack;
      w   = eff_window(reg_copy);
      b   = int'(win_planned.base);
      tot = int'(reg_copy.total_packets);
      sel = $urandom_range(0, 99);
      ack = $urandom_range(0, 131071);
      if (b >= tot && $urandom_range(0, 9) < 4) begin
         queue_item(OP_START, ack);
      end else if (sel < 70) begin
         if (!reg_copy.repeat_mode) ack = b + $urandom_range(1, w);
         else if ($urandom_range(0, 2) == 0) ack = b;
         else ack = b + $urandom_range(0, w - 1);
         queue_item(OP_ACK, ack);
      end else if (sel < 80) begin
         queue_item(OP_TIMEOUT, ack);
      end else if (sel < 84) begin
         queue_item(OP_START, ack);
      end else if (sel < 87) begin
         queue_item(OP_UNUSED, ack);
      end else begin
         case ($urandom_range(0, 4))
            0: ack = (b > 0) ? b - 1 : 0;
            1: ack = b + w;
            2: ack = b + w + 1;
            3: ack = tot;
            default: ;
         endcase
         queue_item(OP_ACK, ack);
      end
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      case (idx)
         CSR_FLIGHT_LIMIT:  reg_copy.flight_limit  = value[WIN_W-1:0];
         CSR_REPEAT_MODE:   reg_copy.repeat_mode   = value[0];
         CSR_TOTAL_PACKETS: reg_copy.total_packets = value[SEQ_W-1:0];
         CSR_PAYLOAD_SIZE:  reg_copy.payload_size  = value[LEN_W-1:0];
         CSR_LAST_LENGTH:   reg_copy.last_length   = value[LEN_W-1:0];
         default: ;
      endcase
      write_cnt++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (accepted_cnt != queued_cnt || expected_sends.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   function automatic int pick_length();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 2047;
         2: return 1500;
         3: return 1;
         default: return $urandom_range(1, 1500);
      endcase
   endfunction

   initial begin : stimulus
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_stall   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      reg_copy.flight_limit  = FLIGHT_LIMIT_RESET;
      reg_copy.repeat_mode   = REPEAT_MODE_RESET;
      reg_copy.total_packets = TOTAL_RESET;
      reg_copy.payload_size  = PAYLOAD_SIZE_RESET;
      reg_copy.last_length   = LAST_LENGTH_RESET;
      win_checked  = '0;
      win_planned  = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults: empty transfer, every event gives a lone status item
      queue_item(OP_START, 0);
      queue_item(OP_ACK, 0);
      queue_item(OP_TIMEOUT, 0);
      queue_item(OP_UNUSED, 0);
      wait_idle();

      // go-back-N: stale, beyond-window, edge-of-window and completing acks
      write_reg(CSR_FLIGHT_LIMIT, 4);
      write_reg(CSR_REPEAT_MODE, 0);
      write_reg(CSR_TOTAL_PACKETS, 10);
      write_reg(CSR_PAYLOAD_SIZE, 1000);
      write_reg(CSR_LAST_LENGTH, 37);
      queue_item(OP_START, 0);
      queue_item(OP_ACK, 0);
      queue_item(OP_ACK, 5);
      queue_item(OP_ACK, 2);
      queue_item(OP_ACK, 6);
      queue_item(OP_TIMEOUT, 0);
      queue_item(OP_UNUSED, 131071);
      queue_item(OP_ACK, 131071);
      queue_item(OP_ACK, 10);
      queue_item(OP_TIMEOUT, 0);
      wait_idle();

      // selective repeat: out-of-order and duplicate acks, then a multi-packet slide
      write_reg(CSR_FLIGHT_LIMIT, 5);
      write_reg(CSR_REPEAT_MODE, 1);
      write_reg(CSR_TOTAL_PACKETS, 12);
      write_reg(CSR_PAYLOAD_SIZE, 2047);
      write_reg(CSR_LAST_LENGTH, 0);
      queue_item(OP_START, 0);
      queue_item(OP_ACK, 2);
      queue_item(OP_ACK, 2);
      queue_item(OP_ACK, 5);
      queue_item(OP_ACK, 0);
      queue_item(OP_ACK, 1);
      queue_item(OP_TIMEOUT, 0);
      wait_idle();

      // zero window acts as one, zero payload size, largest transfer
      write_reg(CSR_FLIGHT_LIMIT, 0);
      write_reg(CSR_TOTAL_PACKETS, 65535);
      write_reg(CSR_PAYLOAD_SIZE, 0);
      write_reg(CSR_LAST_LENGTH, 1500);
      queue_item(OP_START, 0);
      queue_item(OP_ACK, 0);
      queue_item(OP_TIMEOUT, 0);
      wait_idle();

      // oversized window saturates at the maximum
      write_reg(CSR_FLIGHT_LIMIT, 127);
      write_reg(CSR_REPEAT_MODE, 0);
      write_reg(CSR_TOTAL_PACKETS, 100);
      write_reg(CSR_PAYLOAD_SIZE, 1500);
      queue_item(OP_START, 0);
      queue_item(OP_ACK, 64);
      wait_idle();

      while (queued_cnt < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0: write_reg(CSR_FLIGHT_LIMIT, 0);
            1: write_reg(CSR_FLIGHT_LIMIT, 1);
            2: write_reg(CSR_FLIGHT_LIMIT, 64);
            3: write_reg(CSR_FLIGHT_LIMIT, $urandom_range(65, 127));
            default: write_reg(CSR_FLIGHT_LIMIT, $urandom_range(1, 64));
         endcase
         write_reg(CSR_REPEAT_MODE, $urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0: write_reg(CSR_TOTAL_PACKETS, 0);
            1: write_reg(CSR_TOTAL_PACKETS, 65535);
            2: write_reg(CSR_TOTAL_PACKETS, $urandom_range(0, 65535));
            3: write_reg(CSR_TOTAL_PACKETS, 1);
            default: write_reg(CSR_TOTAL_PACKETS, $urandom_range(2, 300));
         endcase
         if ($urandom_range(0, 2) != 0) write_reg(CSR_PAYLOAD_SIZE, pick_length());
         if ($urandom_range(0, 2) != 0) write_reg(CSR_LAST_LENGTH, pick_length());
         queue_item(OP_START, $urandom_range(0, 131071));
         repeat ($urandom_range(20, 60)) begin
            queue_random_item();
         end
         wait_idle();
      end

      repeat (100) @(posedge clock);
      $display("covered %0d items (%0d go-back-N, %0d selective repeat), %0d results, %0d sends",
               accepted_cnt, gbn_cnt, sr_cnt, checked_cnt, send_cnt);
      $display("%0d register writes, %0d long receiver hold-offs", write_cnt, holds_done);
      if (error_cnt == 0) begin
         $display("** sliding_window_sender: PASSED **");
      end else begin
         $display("%0d mismatches", error_cnt);
         $display("** sliding_window_sender: FAILED **");
      end
      $finish;
   end

endmodule
